/* rtl/core/jsu_pkg.sv */
// Package for the JSON string unescape block: payload types, escape codes
// and the decode helpers used by the front end.
// No dependencies.
package jsu_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_HEX    = 2'd2;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CODE_BS   = 8'h08;
  localparam logic [7:0] CODE_FF   = 8'h0C;
  localparam logic [7:0] CODE_LF   = 8'h0A;
  localparam logic [7:0] CODE_CR   = 8'h0D;
  localparam logic [7:0] CODE_TAB  = 8'h09;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_word_t;

  // up to three decoded bytes from one input word; num is 1..3 when queued
  typedef struct packed {
    logic [1:0]      num;
    logic [2:0][7:0] data;
  } batch_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] code;
  } esc_t;

  function automatic esc_t map_escape(logic [7:0] c);
    esc_t r;
    r.ok   = 1'b1;
    r.code = c;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: r.code = c;
      CH_B:    r.code = CODE_BS;
      CH_F:    r.code = CODE_FF;
      CH_N:    r.code = CODE_LF;
      CH_R:    r.code = CODE_CR;
      CH_T:    r.code = CODE_TAB;
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] hex_value(logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  // decode the held \u bytes as the tail of a string (cnt is 1..3)
  function automatic batch_t flush_held(logic [1:0] cnt, logic [2:0][7:0] h);
    batch_t r;
    esc_t   e;
    r = '0;
    if (h[0] == CH_BSLASH && cnt > 2'd1) begin
      e = map_escape(h[1]);
      if (e.ok) begin
        r.data[r.num] = e.code;
        r.num = r.num + 2'd1;
      end
      if (cnt > 2'd2) begin
        r.data[r.num] = h[2];
        r.num = r.num + 2'd1;
      end
    end else begin
      r.data[0] = h[0];
      r.num = 2'd1;
      if (cnt > 2'd1) begin
        if (h[1] == CH_BSLASH && cnt > 2'd2) begin
          e = map_escape(h[2]);
          if (e.ok) begin
            r.data[1] = e.code;
            r.num = 2'd2;
          end
        end else begin
          r.data[1] = h[1];
          r.num = 2'd2;
          if (cnt > 2'd2) begin
            r.data[2] = h[2];
            r.num = 2'd3;
          end
        end
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/jsu_front.sv */
// Front end: escape state machine, one input word per cycle while accept_i
// is high. Produces a batch of 0..3 decoded bytes. Depends on jsu_pkg.
module jsu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  jsu_pkg::in_word_t in_i,
  output logic              batch_valid_o,
  output jsu_pkg::batch_t   batch_o
);
  import jsu_pkg::*;

  logic [1:0]      mode_q, mode_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [7:0]      code_q, code_d;
  logic [2:0][7:0] held_q;
  logic [2:0][7:0] held_view;
  batch_t          batch;
  esc_t            esc;
  logic [7:0]      b;
  logic            last;

  assign b    = in_i.in_byte;
  assign last = in_i.in_last;
  assign esc  = map_escape(b);

  always_comb begin
    held_view = held_q;
    held_view[cnt_q] = b;
  end

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    code_d = code_q;
    batch  = '0;
    case (mode_q)
      MODE_ESC: begin
        mode_d = MODE_NORMAL;
        if (esc.ok) begin
          batch.num     = 2'd1;
          batch.data[0] = esc.code;
        end else if (b == CH_U && !last) begin
          mode_d = MODE_HEX;
          cnt_d  = 2'd0;
          code_d = 8'd0;
        end
      end
      MODE_HEX: begin
        code_d = {code_q[3:0], hex_value(b)};
        if (cnt_q == 2'd3) begin
          batch.num     = 2'd1;
          batch.data[0] = code_d;
          mode_d        = MODE_NORMAL;
          cnt_d         = 2'd0;
        end else begin
          cnt_d = cnt_q + 2'd1;
          if (last) begin
            batch = flush_held(cnt_q + 2'd1, held_view);
          end
        end
      end
      default: begin
        mode_d = MODE_NORMAL;
        if (b == CH_BSLASH && !last) begin
          mode_d = MODE_ESC;
        end else begin
          batch.num     = 2'd1;
          batch.data[0] = b;
        end
      end
    endcase
    if (last) begin
      mode_d = MODE_NORMAL;
      cnt_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      cnt_q  <= 2'd0;
      code_q <= 8'd0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      code_q <= code_d;
    end
  end

  // held digits are only read after being written in the same \u run
  always_ff @(posedge clk_i) begin
    if (accept_i && mode_q == MODE_HEX && cnt_q != 2'd3) begin
      held_q[cnt_q] <= b;
    end
  end

  assign batch_valid_o = accept_i && (batch.num != 2'd0);
  assign batch_o       = batch;

endmodule

/* rtl/core/jsu_queue.sv */
// Short register queue of decoded batches between front and back end.
// Depends on jsu_pkg.
module jsu_queue #(
  parameter int unsigned Depth = jsu_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  jsu_pkg::batch_t data_i,
  input  logic            pop_i,
  output jsu_pkg::batch_t data_o,
  output logic            full_o,
  output logic            empty_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  batch_t          mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

/* rtl/core/jsu_back.sv */
// Back end: walks the head batch of the queue one byte per pop and marks
// the last byte of each batch. Depends on jsu_pkg.
module jsu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jsu_pkg::batch_t    head_i,
  input  logic               head_empty_i,
  input  logic               pop_i,
  output logic               head_pop_o,
  output jsu_pkg::out_word_t out_o
);
  import jsu_pkg::*;

  logic [1:0] idx_q;
  logic       at_end;
  logic       take;

  assign at_end         = (idx_q == head_i.num - 2'd1);
  assign take           = pop_i && !head_empty_i;
  assign head_pop_o     = take && at_end;
  assign out_o.out_byte = head_i.data[idx_q];
  assign out_o.run_last = at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (take) begin
      idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

/* rtl/core/json_string_unescape.sv */
// Top level of the JSON string unescape block.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
// Usage:
//   Input queue side: drive in_i (raw byte plus end-of-string flag) and
//   push; a word is taken at a clock edge with push high and full low.
//   Output queue side: while empty is low, out_o shows the oldest decoded
//   byte; it is taken at a clock edge with pop high. run_last marks the
//   final byte produced by one input byte.
//   Decoded bytes are registered in the batch queue before they reach out_o.
//   Throughput: one input byte per cycle while each byte yields at most
//   one result and pop keeps up; a string that ends inside \u can yield up
//   to three bytes, which drain from the batch queue (QueueDepth batches)
//   at one per cycle while pop is high and hold off input once it fills.
//   Escape bytes, \u digits and unknown escapes give no output of their own.
//   Reset (rst_ni low) clears the decoder state and the queue; no output
//   is pending afterwards. If the receiver stalls, the result stays on
//   out_o and full rises once the queue fills.
module json_string_unescape #(
  parameter int unsigned QDepth = jsu_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jsu_pkg::in_word_t  in_i,
  input  logic               push,
  output logic               full,
  output jsu_pkg::out_word_t out_o,
  output logic               empty,
  input  logic               pop
);
  import jsu_pkg::*;

  logic   accept;
  logic   batch_valid;
  batch_t batch;
  batch_t head;
  logic   head_pop;

  assign accept = push && !full;

  jsu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_i          (in_i),
    .batch_valid_o (batch_valid),
    .batch_o       (batch)
  );

  jsu_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (batch_valid),
    .data_i  (batch),
    .pop_i   (head_pop),
    .data_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (empty),
    .pop_i        (pop),
    .head_pop_o   (head_pop),
    .out_o        (out_o)
  );

endmodule

/* rtl/core/jsu_checker.sv */
// Port-level checks for json_string_unescape, attached by bind.
// Depends on jsu_pkg and the top level.
module jsu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               full,
  input jsu_pkg::out_word_t out_o,
  input logic               empty,
  input logic               pop
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_o)))
    else $error("result changed while stalled");

  a_full_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("full with no result waiting");

  a_reset_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> (empty && !full))
    else $error("result pending after reset");

  a_batch_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !out_o.run_last) |=> !empty)
    else $error("batch ended without run_last");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .full   (full),
  .out_o  (out_o),
  .empty  (empty),
  .pop    (pop)
);
